// ----- rtl/core/ddo_pkg.sv -----
// ddo_pkg: types, codes and constants shared by the odometry core
// and its cordic unit; depends on nothing
`timescale 1ns / 1ps

package ddo_pkg;

   // cordic datapath width (x, y and angle in q30 with headroom)
   localparam int CW = 36;

   // product and accumulator widths of the position step
   localparam int MA_W  = 34;
   localparam int MB_W  = 17;
   localparam int MP_W  = MA_W + MB_W;
   localparam int ACC_W = 67;

   // angle constants
   localparam logic signed [25:0]   TWO_PI_Q20  = 26'sd6588397;
   localparam logic signed [CW-1:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [CW-1:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [CW-1:0] TWO_PI_Q30  = 36'sd6746518852;
   localparam logic signed [CW-1:0] GAIN_Q30    = 36'sd652032874;

   // arctangent of 2^-i in q30, truncated
   localparam logic [30:0] ATAN_TAB [32] = '{
      31'h3243F6A8, 31'h1DAC6705, 31'h0FADBAFC, 31'h07F56EA6, 31'h03FEAB76,
      31'h01FFD55B, 31'h00FFFAAA, 31'h007FFF55, 31'h003FFFEA, 31'h001FFFFD,
      31'h000FFFFF, 31'h0007FFFF, 31'h0003FFFF, 31'h0001FFFF, 31'h0000FFFF,
      31'h00007FFF, 31'h00003FFF, 31'h00001FFF, 31'h00000FFF, 31'h000007FF,
      31'h000003FF, 31'h000001FF, 31'h000000FF, 31'h0000007F, 31'h0000003F,
      31'h0000001F, 31'h0000000F, 31'h00000008, 31'h00000004, 31'h00000002,
      31'h00000001, 31'h00000000
   };

   // command codes
   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_LOAD   = 1'b1;

   // register indexes
   localparam logic [1:0] CSR_STEP_LENGTH = 2'd0;
   localparam logic [1:0] CSR_WHEEL_BASE  = 2'd1;

   typedef struct packed {
      logic               command;
      logic signed [15:0] left_steps;
      logic signed [15:0] right_steps;
      logic signed [31:0] load_x;
      logic signed [31:0] load_y;
      logic signed [23:0] load_heading;
   } ddo_req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [23:0] heading;
   } ddo_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_YMUL, ST_VINIT, ST_VEC, ST_WRAP, ST_RINIT, ST_ROT, ST_CS,
      ST_MXH, ST_MXL, ST_MYH, ST_MYL, ST_MFIN, ST_POS, ST_DONE
   } ddo_state_type;

   typedef struct packed {
      logic start;
      logic vectoring;
   } ddo_cordic_ctrl_type;

   typedef struct packed {
      logic running;
      logic done;
   } ddo_cordic_stat_type;

endpackage

// ----- rtl/core/ddo_cordic.sv -----
// ddo_cordic: one shared shift-add cordic stage, iterated in vectoring or
// rotation mode; depends on ddo_pkg
`timescale 1ns / 1ps

module ddo_cordic #(
   parameter int ITERATIONS = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ddo_pkg::ddo_cordic_ctrl_type  ctrl,
   input  logic signed [ddo_pkg::CW-1:0] x0,
   input  logic signed [ddo_pkg::CW-1:0] y0,
   input  logic signed [ddo_pkg::CW-1:0] z0,
   output logic signed [ddo_pkg::CW-1:0] x,
   output logic signed [ddo_pkg::CW-1:0] y,
   output logic signed [ddo_pkg::CW-1:0] z,
   output ddo_pkg::ddo_cordic_stat_type  stat
);
   import ddo_pkg::*;

   localparam logic [4:0] LAST = 5'(ITERATIONS - 1);

   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic                 run_ff, run_in, vec_ff, vec_in;
   logic signed [CW-1:0] xs, ys, at;
   logic                 rot_pos;

   // one micro-rotation per cycle
   always_comb begin
      xs      = x_ff >>> cnt_ff;
      ys      = y_ff >>> cnt_ff;
      at      = $signed({5'b0, ATAN_TAB[cnt_ff]});
      rot_pos = vec_ff ? y_ff[CW-1] : !z_ff[CW-1];
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      vec_in  = vec_ff;
      if (ctrl.start) begin
         x_in   = x0;
         y_in   = y0;
         z_in   = z0;
         cnt_in = '0;
         run_in = 1'b1;
         vec_in = ctrl.vectoring;
      end else if (run_ff) begin
         if (rot_pos) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == LAST) run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      vec_ff <= vec_in;
   end

   assign x            = x_ff;
   assign y            = y_ff;
   assign z            = z_ff;
   assign stat.running = run_ff;
   assign stat.done    = run_ff && (cnt_ff == LAST);

   // the run ends right after the last micro-rotation
   a_done_stops: assert property (@(posedge clock) disable iff (reset)
      (stat.done && !ctrl.start) |=> !run_ff)
      else $error("cordic kept running after last step");

   // a start always begins at step zero
   a_start_zero: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |=> (run_ff && cnt_ff == 5'd0))
      else $error("cordic start did not restart the count");

   // the step count never passes the last step while running
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> (cnt_ff <= LAST))
      else $error("cordic step count out of range");

endmodule

// ----- rtl/core/differential_drive_odometry.sv -----
// differential_drive_odometry: top level of the pose integrator
// depends on ddo_pkg and ddo_cordic
`timescale 1ns / 1ps

// Two-wheel dead-reckoning odometry. A request word either loads the pose
// or brings the left and right step counts of one period; every request
// returns one response word with x, y (Q16.16 cm, saturating) and heading
// (Q4.20 rad, kept inside plus or minus two pi by each update). A load
// goes straight to the done state, which fills the response register; an
// update first runs the one shared cordic stage as an arctangent and then
// as sine/cosine, followed by four passes through one 34x17 multiplier for
// the position step. req_stall is high while a request is being worked
// on. The response sits in an output register, so the next request is
// taken while it waits. Registers (step_length, wheel_base) are written
// through the csr port; csr_ready is high only while idle.

module differential_drive_odometry #(
   parameter int CORDIC_ITERATIONS = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  ddo_pkg::ddo_req_type req_data,
   output logic                 req_stall,
   output logic                 rsp_valid,
   output ddo_pkg::ddo_rsp_type rsp_data,
   input  logic                 rsp_stall,
   input  logic                 csr_valid,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_data,
   output logic                 csr_ready
);
   import ddo_pkg::*;

   ddo_state_type state_ff, state_in;

   logic [15:0]           step_ff, step_in, wheel_ff, wheel_in;
   logic signed [31:0]    x_ff, x_in, y_ff, y_in;
   logic signed [23:0]    angle_ff, angle_in;
   logic signed [15:0]    diff_ff, diff_in;
   logic signed [16:0]    sum_ff, sum_in;
   logic signed [MP_W-1:0] mul_ff, mul_in;
   logic                  yzero_ff, yzero_in, neg_ff, neg_in;
   logic signed [MA_W-1:0] dist_ff, dist_in;
   logic signed [32:0]    c_ff, c_in, s_ff, s_in;
   logic signed [ACC_W-1:0] accx_ff, accx_in, accy_ff, accy_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   ddo_rsp_type           rsp_data_ff, rsp_data_in;

   logic                  req_take, rsp_free;
   logic signed [MA_W-1:0] mul_a;
   logic signed [MB_W-1:0] mul_b;
   ddo_cordic_ctrl_type   cctrl;
   ddo_cordic_stat_type   cstat;
   logic signed [CW-1:0]  cx0, cy0, cz0, cx, cy, cz;
   logic signed [CW-1:0]  phi, rnd, za, zb, zc;
   logic signed [25:0]    hsum, hwrap;
   logic                  zneg;
   logic signed [ACC_W-1:0] rx_full, ry_full;
   logic signed [36:0]    nx, ny;

   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !(rsp_valid_ff && rsp_stall);
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   ddo_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
      .clock (clock),
      .reset (reset),
      .ctrl  (cctrl),
      .x0    (cx0),
      .y0    (cy0),
      .z0    (cz0),
      .x     (cx),
      .y     (cy),
      .z     (cz),
      .stat  (cstat)
   );

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) state_in = (req_data.command == CMD_LOAD) ? ST_DONE : ST_YMUL;
         end
         ST_YMUL:  state_in = ST_VINIT;
         ST_VINIT: state_in = ST_VEC;
         ST_VEC:   if (cstat.done) state_in = ST_WRAP;
         ST_WRAP:  state_in = ST_RINIT;
         ST_RINIT: state_in = ST_ROT;
         ST_ROT:   if (cstat.done) state_in = ST_CS;
         ST_CS:    state_in = ST_MXH;
         ST_MXH:   state_in = ST_MXL;
         ST_MXL:   state_in = ST_MYH;
         ST_MYH:   state_in = ST_MYL;
         ST_MYL:   state_in = ST_MFIN;
         ST_MFIN:  state_in = ST_POS;
         ST_POS:   state_in = ST_DONE;
         ST_DONE:  if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // angle reduction for the rotation pass: into +-pi, then fold to +-pi/2
   always_comb begin
      za = $signed(CW'(angle_ff)) <<< 10;
      if (za > PI_Q30)       zb = za - TWO_PI_Q30;
      else if (za < -PI_Q30) zb = za + TWO_PI_Q30;
      else                   zb = za;
      zneg = 1'b0;
      zc   = zb;
      if (zb > HALF_PI_Q30) begin
         zc   = zb - PI_Q30;
         zneg = 1'b1;
      end else if (zb < -HALF_PI_Q30) begin
         zc   = zb + PI_Q30;
         zneg = 1'b1;
      end
   end

   // sequencer outputs: cordic control and multiplier operands
   always_comb begin
      cctrl = '0;
      cx0   = '0;
      cy0   = '0;
      cz0   = '0;
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_YMUL: begin
            mul_a = MA_W'(diff_ff);
            mul_b = $signed({1'b0, step_ff});
         end
         ST_VINIT: begin
            cctrl.start     = 1'b1;
            cctrl.vectoring = 1'b1;
            cx0 = $signed(CW'({wheel_ff, 8'b0}));
            cy0 = mul_ff[CW-1:0];
         end
         ST_RINIT: begin
            cctrl.start = 1'b1;
            cx0   = GAIN_Q30;
            cz0   = zc;
            mul_a = MA_W'(sum_ff);
            mul_b = $signed({1'b0, step_ff});
         end
         ST_MXH: begin
            mul_a = dist_ff;
            mul_b = c_ff[32:16];
         end
         ST_MXL: begin
            mul_a = dist_ff;
            mul_b = $signed({1'b0, c_ff[15:0]});
         end
         ST_MYH: begin
            mul_a = dist_ff;
            mul_b = s_ff[32:16];
         end
         ST_MYL: begin
            mul_a = dist_ff;
            mul_b = $signed({1'b0, s_ff[15:0]});
         end
         default: begin
            cctrl = '0;
         end
      endcase
   end

   // heading update: round the q30 turn to q20, negate, wrap by two pi
   always_comb begin
      phi  = yzero_ff ? '0 : cz;
      rnd  = (phi + CW'(512)) >>> 10;
      hsum = $signed(26'(angle_ff)) - rnd[25:0];
      if (hsum >= TWO_PI_Q20)       hwrap = hsum - TWO_PI_Q20;
      else if (hsum <= -TWO_PI_Q20) hwrap = hsum + TWO_PI_Q20;
      else                          hwrap = hsum;
   end

   // position step: round off 31 bits and add; ST_POS saturates the sum
   always_comb begin
      rx_full = (accx_ff + (ACC_W'(1) <<< 30)) >>> 31;
      ry_full = (accy_ff + (ACC_W'(1) <<< 30)) >>> 31;
      nx = 37'(x_ff) + rx_full[36:0];
      ny = 37'(y_ff) + ry_full[36:0];
   end

   // datapath register updates
   always_comb begin
      step_in      = step_ff;
      wheel_in     = wheel_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      angle_in     = angle_ff;
      diff_in      = diff_ff;
      sum_in       = sum_ff;
      mul_in       = mul_a * mul_b;
      yzero_in     = yzero_ff;
      neg_in       = neg_ff;
      dist_in      = dist_ff;
      c_in         = c_ff;
      s_in         = s_ff;
      accx_in      = accx_ff;
      accy_in      = accy_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      // register writes
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_STEP_LENGTH: step_in  = csr_data;
            CSR_WHEEL_BASE:  wheel_in = csr_data;
            default:         step_in  = step_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               diff_in = req_data.left_steps - req_data.right_steps;
               sum_in  = 17'(req_data.left_steps) + 17'(req_data.right_steps);
               if (req_data.command == CMD_LOAD) begin
                  x_in     = req_data.load_x;
                  y_in     = req_data.load_y;
                  angle_in = req_data.load_heading;
               end
            end
         end
         ST_VINIT: yzero_in = (mul_ff == '0);
         ST_WRAP:  angle_in = hwrap[23:0];
         // distance product taken straight off the multiplier
         ST_RINIT: begin
            neg_in  = zneg;
            dist_in = mul_in[MA_W-1:0];
         end
         ST_CS: begin
            c_in = neg_ff ? -cx[32:0] : cx[32:0];
            s_in = neg_ff ? -cy[32:0] : cy[32:0];
         end
         ST_MXL:  accx_in = ACC_W'(mul_ff) <<< 16;
         ST_MYH:  accx_in = accx_ff + ACC_W'(mul_ff);
         ST_MYL:  accy_in = ACC_W'(mul_ff) <<< 16;
         ST_MFIN: accy_in = accy_ff + ACC_W'(mul_ff);
         ST_POS: begin
            if (nx > 37'sd2147483647)       x_in = 32'sh7FFFFFFF;
            else if (nx < -37'sd2147483648) x_in = 32'sh80000000;
            else                            x_in = nx[31:0];
            if (ny > 37'sd2147483647)       y_in = 32'sh7FFFFFFF;
            else if (ny < -37'sd2147483648) y_in = 32'sh80000000;
            else                            y_in = ny[31:0];
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.pos_x   = x_ff;
               rsp_data_in.pos_y   = y_ff;
               rsp_data_in.heading = angle_ff;
            end
         end
         default: begin
            dist_in = dist_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= 16'd852;
         wheel_ff     <= 16'd1357;
         x_ff         <= '0;
         y_ff         <= '0;
         angle_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         wheel_ff     <= wheel_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         angle_ff     <= angle_in;
      end
      diff_ff     <= diff_in;
      sum_ff      <= sum_in;
      mul_ff      <= mul_in;
      yzero_ff    <= yzero_in;
      neg_ff      <= neg_in;
      dist_ff     <= dist_in;
      c_ff        <= c_in;
      s_ff        <= s_in;
      accx_ff     <= accx_in;
      accy_ff     <= accy_in;
      rsp_data_ff <= rsp_data_in;
   end

   // a load goes straight to the response
   a_load_direct: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && req_data.command == CMD_LOAD)
      |=> state_ff == ST_DONE)
      else $error("load did not go straight to response");

   // the wrapped heading stays inside plus or minus two pi
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRAP |=>
      ($signed(26'(angle_ff)) > -TWO_PI_Q20 && $signed(26'(angle_ff)) < TWO_PI_Q20))
      else $error("heading left the wrap range");

   // the cordic is busy whenever the sequencer waits on it
   a_cordic_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_VEC || state_ff == ST_ROT) |-> cstat.running)
      else $error("sequencer waits on an idle cordic");

endmodule
